// ----- design/vna_pkg.sv -----
// Shared types and constants for the vertex normal accumulator.
// Used by every module of the block; no dependencies.
package vna_pkg;

    localparam int VERTICES_DEFAULT = 1024;
    localparam int IDX_W = 10;
    localparam int COORD_W = 12;
    localparam int POS_W = 3 * COORD_W;
    localparam int EDGE_W = COORD_W + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W = 56;
    localparam int ROOT_W = MAG_W / 2;
    localparam int WGT_ADD_W = ROOT_W - 1;
    localparam int SUM_W = 40;
    localparam int SUM_WORD_W = 4 * SUM_W;
    localparam int FRAC_SHIFT = 12;
    localparam int DVD_W = SUM_W + FRAC_SHIFT;
    localparam int NORM_W = 16;
    localparam int NORM_LIMIT = 16384;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 3 * NORM_W;
    localparam int CALC_CYCLES = 6;
    localparam int CNT_W = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic       load_item;
        logic       clear_wr;
        logic       pos_wr;
        logic       pos_rd;
        logic       sum_rd;
        logic       sum_wr;
        logic       sum_zero;
        logic       use_corner;
        logic [1:0] corner;
        logic       root_start;
        logic       div_start;
        logic       load_res;
        logic       res_norm;
    } vna_cmd_t;

    typedef struct packed {
        op_t  op;
        logic idx_ok;
        logic tri_ok;
        logic root_done;
        logic div_done;
        logic wsum_zero;
        logic clear_last;
        logic out_busy;
    } vna_sts_t;

endpackage

// ----- design/vna_isqrt.sv -----
// Iterative integer square root, floored, one result bit per cycle.
// Depends on vna_pkg.
module vna_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [vna_pkg::MAG_W-1:0] radicand,
    output logic                      done,
    output logic [vna_pkg::ROOT_W-1:0] root
);

    localparam int MW = vna_pkg::MAG_W;
    localparam int RW = vna_pkg::ROOT_W;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] nsh_reg, nsh_next;
    logic [RW+1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW+3:0] shifted;
    logic [RW+3:0] trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        nsh_next  = nsh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        shifted   = {rem_reg, nsh_reg[MW-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(RW);
            nsh_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            nsh_next = {nsh_reg[MW-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_next  = (RW+2)'(shifted - trial);
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = shifted[RW+1:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        nsh_reg  <= nsh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = !busy_reg;
    assign root = root_reg;

endmodule

// ----- design/vna_div.sv -----
// Three-lane restoring divider: 4096 * sum / weight, truncated, clamped.
// One quotient bit per cycle in each lane. Depends on vna_pkg.
module vna_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [2:0][vna_pkg::SUM_W-1:0]        sum_in,
    input  logic [vna_pkg::SUM_W-1:0]             weight,
    output logic                                  done,
    output logic [2:0][vna_pkg::NORM_W-1:0]       norm_out
);

    localparam int SW = vna_pkg::SUM_W;
    localparam int DW = vna_pkg::DVD_W;
    localparam int NW = vna_pkg::NORM_W;
    localparam int CW = $clog2(DW + 1);

    logic                busy_reg, busy_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SW-1:0]       wgt_reg, wgt_next;
    logic [2:0]          neg_reg, neg_next;
    logic [2:0][DW-1:0]  dvd_reg, dvd_next;
    logic [2:0][SW-1:0]  rem_reg, rem_next;
    logic [2:0][DW-1:0]  quo_reg, quo_next;
    logic [2:0][SW:0]    shifted;
    logic [2:0][SW-1:0]  mag;
    logic [2:0][NW-1:0]  clamped;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        wgt_next  = wgt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        for (int i = 0; i < 3; i++) begin
            mag[i]     = sum_in[i][SW-1] ? SW'(~sum_in[i] + 1'b1) : sum_in[i];
            shifted[i] = {rem_reg[i], dvd_reg[i][DW-1]};
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            wgt_next  = weight;
            for (int i = 0; i < 3; i++) begin
                neg_next[i] = sum_in[i][SW-1];
                dvd_next[i] = {mag[i], {vna_pkg::FRAC_SHIFT{1'b0}}};
                rem_next[i] = '0;
                quo_next[i] = '0;
            end
        end else if (busy_reg) begin
            for (int i = 0; i < 3; i++) begin
                dvd_next[i] = {dvd_reg[i][DW-2:0], 1'b0};
                if (shifted[i] >= {1'b0, wgt_reg}) begin
                    rem_next[i] = SW'(shifted[i] - {1'b0, wgt_reg});
                    quo_next[i] = {quo_reg[i][DW-2:0], 1'b1};
                end else begin
                    rem_next[i] = shifted[i][SW-1:0];
                    quo_next[i] = {quo_reg[i][DW-2:0], 1'b0};
                end
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (quo_reg[i] > DW'(vna_pkg::NORM_LIMIT)) begin
                clamped[i] = NW'(vna_pkg::NORM_LIMIT);
            end else begin
                clamped[i] = quo_reg[i][NW-1:0];
            end
            norm_out[i] = neg_reg[i] ? NW'(~clamped[i] + 1'b1) : clamped[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        wgt_reg <= wgt_next;
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = !busy_reg;

endmodule

// ----- design/vna_dp.sv -----
// Datapath: item register, vertex and sum memories, cross product and
// magnitude pipeline, saturating update and result register.
// Depends on vna_pkg, vna_isqrt and vna_div.
module vna_dp #(
    parameter int VERTICES = vna_pkg::VERTICES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  vna_pkg::vna_cmd_t               cmd,
    output vna_pkg::vna_sts_t               sts,
    input  logic [vna_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vna_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser
);

    localparam int AW  = $clog2(VERTICES);
    localparam int IW  = vna_pkg::IDX_W;
    localparam int CRW = vna_pkg::COORD_W;
    localparam int PW  = vna_pkg::POS_W;
    localparam int EW  = vna_pkg::EDGE_W;
    localparam int XW  = vna_pkg::PROD_W;
    localparam int CXW = vna_pkg::CROSS_W;
    localparam int SW  = vna_pkg::SUM_W;
    localparam int SQW = 2 * CXW;
    localparam int MW  = vna_pkg::MAG_W;
    localparam int GW  = vna_pkg::WGT_ADD_W;

    vna_pkg::op_t          op_reg;
    logic [IW-1:0]         vidx_reg;
    logic [PW-1:0]         coord_reg;
    logic [2:0][IW-1:0]    corner_reg;

    logic [31:0]           vidx_ext;
    logic [2:0][31:0]      corner_ext;
    logic [AW-1:0]         vidx_addr;
    logic [AW-1:0]         corner_addr;
    logic [AW-1:0]         sum_addr;
    logic [AW-1:0]         clr_addr_reg;

    logic [PW-1:0]         pos_mem [VERTICES];
    logic [PW-1:0]         pos_rdata_reg;
    logic                  pos_we;
    logic [AW-1:0]         pos_waddr;
    logic [PW-1:0]         pos_wdata;
    logic                  cap_pend_reg;
    logic [1:0]            cap_slot_reg;
    logic [PW-1:0]         vtx_reg [3];

    logic [vna_pkg::SUM_WORD_W-1:0] sum_mem [VERTICES];
    logic [vna_pkg::SUM_WORD_W-1:0] sum_rdata_reg;
    logic                           sum_we;
    logic [AW-1:0]                  sum_waddr;
    logic [vna_pkg::SUM_WORD_W-1:0] sum_wdata;
    logic [vna_pkg::SUM_WORD_W-1:0] sum_upd;

    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [XW-1:0]  prod_reg [6];
    logic signed [CXW-1:0] cross_reg [3];
    logic signed [SQW-1:0] cross_wide [3];
    logic [SQW-1:0]        sq_reg [3];
    logic [MW-1:0]         mag_reg;

    logic [vna_pkg::ROOT_W-1:0]      root;
    logic [GW-1:0]                   wgt_add;
    logic [2:0][SW-1:0]              sum_old;
    logic signed [SW:0]              sum_new [3];
    logic [SW:0]                     wgt_new;
    logic [2:0][vna_pkg::NORM_W-1:0] norm;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [vna_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    function automatic logic signed [EW-1:0] coord_diff(logic [CRW-1:0] p, logic [CRW-1:0] q);
        logic signed [EW-1:0] pe;
        logic signed [EW-1:0] qe;
        pe = EW'(signed'(p));
        qe = EW'(signed'(q));
        return pe - qe;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg        <= vna_pkg::op_t'(s_tuser);
            vidx_reg      <= s_tdata[IW-1:0];
            coord_reg     <= s_tdata[IW +: PW];
            corner_reg[0] <= s_tdata[IW+PW +: IW];
            corner_reg[1] <= s_tdata[2*IW+PW +: IW];
            corner_reg[2] <= s_tdata[3*IW+PW +: IW];
        end
    end

    assign vidx_ext  = 32'(vidx_reg);
    assign vidx_addr = vidx_ext[AW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            corner_ext[i] = 32'(corner_reg[i]);
        end
        case (cmd.corner)
            2'd1:    corner_addr = corner_ext[1][AW-1:0];
            2'd2:    corner_addr = corner_ext[2][AW-1:0];
            default: corner_addr = corner_ext[0][AW-1:0];
        endcase
    end

    assign sum_addr = cmd.use_corner ? corner_addr : vidx_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign pos_we    = cmd.clear_wr | cmd.pos_wr;
    assign pos_waddr = cmd.clear_wr ? clr_addr_reg : vidx_addr;
    assign pos_wdata = cmd.clear_wr ? '0 : coord_reg;

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (cmd.pos_rd) begin
            pos_rdata_reg <= pos_mem[corner_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_pend_reg <= 1'b0;
            cap_slot_reg <= '0;
        end else begin
            cap_pend_reg <= cmd.pos_rd;
            cap_slot_reg <= cmd.corner;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_pend_reg) begin
            case (cap_slot_reg)
                2'd1:    vtx_reg[1] <= pos_rdata_reg;
                2'd2:    vtx_reg[2] <= pos_rdata_reg;
                default: vtx_reg[0] <= pos_rdata_reg;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cross_wide[i] = SQW'(cross_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            e1_reg[i] <= coord_diff(vtx_reg[1][i*CRW +: CRW], vtx_reg[0][i*CRW +: CRW]);
            e2_reg[i] <= coord_diff(vtx_reg[2][i*CRW +: CRW], vtx_reg[0][i*CRW +: CRW]);
        end
        prod_reg[0] <= e1_reg[1] * e2_reg[2];
        prod_reg[1] <= e1_reg[2] * e2_reg[1];
        prod_reg[2] <= e1_reg[2] * e2_reg[0];
        prod_reg[3] <= e1_reg[0] * e2_reg[2];
        prod_reg[4] <= e1_reg[0] * e2_reg[1];
        prod_reg[5] <= e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++) begin
            cross_reg[i] <= CXW'(prod_reg[2*i]) - CXW'(prod_reg[2*i+1]);
            sq_reg[i]    <= cross_wide[i] * cross_wide[i];
        end
        mag_reg <= MW'(sq_reg[0]) + MW'(sq_reg[1]) + MW'(sq_reg[2]);
    end

    vna_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (mag_reg),
        .done     (sts.root_done),
        .root     (root)
    );

    assign wgt_add = root[vna_pkg::ROOT_W-1:1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_old[i] = sum_rdata_reg[i*SW +: SW];
            sum_new[i] = (SW+1)'(signed'(sum_old[i])) + (SW+1)'(cross_reg[i]) * 2;
            if (sum_new[i][SW] != sum_new[i][SW-1]) begin
                sum_upd[i*SW +: SW] = sum_new[i][SW] ? {1'b1, {(SW-1){1'b0}}}
                                                     : {1'b0, {(SW-1){1'b1}}};
            end else begin
                sum_upd[i*SW +: SW] = sum_new[i][SW-1:0];
            end
        end
        wgt_new = {1'b0, sum_rdata_reg[3*SW +: SW]} + (SW+1)'(wgt_add);
        sum_upd[3*SW +: SW] = wgt_new[SW] ? '1 : wgt_new[SW-1:0];
    end

    assign sum_we    = cmd.clear_wr | cmd.sum_wr;
    assign sum_waddr = cmd.clear_wr ? clr_addr_reg : sum_addr;
    assign sum_wdata = (cmd.clear_wr || cmd.sum_zero) ? '0 : sum_upd;

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (cmd.sum_rd) begin
            sum_rdata_reg <= sum_mem[sum_addr];
        end
    end

    vna_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .sum_in   (sum_rdata_reg[3*SW-1:0]),
        .weight   (sum_rdata_reg[3*SW +: SW]),
        .done     (sts.div_done),
        .norm_out (norm)
    );

    assign m_tvalid_next = cmd.load_res | (m_tvalid_reg & !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (cmd.load_res) begin
            m_tdata_reg <= cmd.res_norm ? {norm[2], norm[1], norm[0]} : '0;
            m_tuser_reg <= cmd.res_norm;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign sts.op         = op_reg;
    assign sts.idx_ok     = vidx_ext < 32'(VERTICES);
    assign sts.tri_ok     = (corner_ext[0] < 32'(VERTICES)) && (corner_ext[1] < 32'(VERTICES))
                            && (corner_ext[2] < 32'(VERTICES));
    assign sts.wsum_zero  = (sum_rdata_reg[3*SW +: SW] == '0);
    assign sts.clear_last = (clr_addr_reg == AW'(VERTICES - 1));
    assign sts.out_busy   = m_tvalid_reg & !m_tready;

endmodule

// ----- design/vna_ctrl.sv -----
// Controller: clearing pass after reset and the per-operation sequence.
// Drives the datapath by command struct. Depends on vna_pkg.
module vna_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  vna_pkg::vna_sts_t sts,
    output vna_pkg::vna_cmd_t cmd
);

    typedef enum logic [14:0] {
        ST_CLEAR   = 15'b000000000000001,
        ST_IDLE    = 15'b000000000000010,
        ST_DECODE  = 15'b000000000000100,
        ST_POS_WR  = 15'b000000000001000,
        ST_SUM_CLR = 15'b000000000010000,
        ST_FETCH   = 15'b000000000100000,
        ST_CALC    = 15'b000000001000000,
        ST_ROOT_GO = 15'b000000010000000,
        ST_ROOT    = 15'b000000100000000,
        ST_UPD_RD  = 15'b000001000000000,
        ST_UPD_WR  = 15'b000010000000000,
        ST_SUM_RD  = 15'b000100000000000,
        ST_SUM_CHK = 15'b001000000000000,
        ST_DIVIDE  = 15'b010000000000000,
        ST_RESULT  = 15'b100000000000000
    } state_t;

    localparam int CW = vna_pkg::CNT_W;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          has_reg, has_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        has_next   = has_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    has_next      = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts.op)
                    vna_pkg::OP_WRITE: state_next = sts.idx_ok ? ST_POS_WR : ST_RESULT;
                    vna_pkg::OP_ADD:   state_next = sts.tri_ok ? ST_FETCH : ST_RESULT;
                    vna_pkg::OP_READ:  state_next = sts.idx_ok ? ST_SUM_RD : ST_RESULT;
                    vna_pkg::OP_CLEAR: state_next = sts.idx_ok ? ST_SUM_CLR : ST_RESULT;
                    default:           state_next = ST_RESULT;
                endcase
            end
            ST_POS_WR: begin
                cmd.pos_wr = 1'b1;
                state_next = ST_RESULT;
            end
            ST_SUM_CLR: begin
                cmd.sum_wr   = 1'b1;
                cmd.sum_zero = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_FETCH: begin
                cmd.pos_rd = 1'b1;
                cmd.corner = cnt_reg[1:0];
                if (cnt_reg == CW'(2)) begin
                    cnt_next   = '0;
                    state_next = ST_CALC;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CALC: begin
                if (cnt_reg == CW'(vna_pkg::CALC_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ROOT_GO;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT_GO: begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                if (sts.root_done) begin
                    cnt_next   = '0;
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD: begin
                cmd.sum_rd     = 1'b1;
                cmd.use_corner = 1'b1;
                cmd.corner     = cnt_reg[1:0];
                state_next     = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                cmd.sum_wr     = 1'b1;
                cmd.use_corner = 1'b1;
                cmd.corner     = cnt_reg[1:0];
                if (cnt_reg == CW'(2)) begin
                    state_next = ST_RESULT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_UPD_RD;
                end
            end
            ST_SUM_RD: begin
                cmd.sum_rd = 1'b1;
                state_next = ST_SUM_CHK;
            end
            ST_SUM_CHK: begin
                if (sts.wsum_zero) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.div_start = 1'b1;
                    has_next      = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.load_res = 1'b1;
                    cmd.res_norm = has_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            has_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            has_reg   <= has_next;
        end
    end

`ifndef SYNTH
    a_load_res_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_res |-> !sts.out_busy)
        else $error("result loaded over a pending transfer");
    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sum_wr && cmd.use_corner) |-> $past(cmd.sum_rd && cmd.use_corner))
        else $error("accumulator update without preceding read");
    a_root_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.root_start |-> sts.root_done)
        else $error("square root restarted while busy");
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !sts.div_done)
        else $error("divider did not start");
`endif

endmodule

// ----- design/vertex_normal_accumulator.sv -----
// Top level of the area-weighted vertex normal accumulator.
// Instantiates vna_ctrl and vna_dp; depends on vna_pkg.
//
// One operation per input transfer, one result transfer per operation. After
// reset a clearing pass zeroes both stores, one entry per cycle, with s_tready
// low. A triangle add makes three vertex reads, runs a cross product and
// magnitude pipeline and a square root, then makes three read-modify-write
// passes on the accumulator memory; a normal read with a nonzero weight runs
// the three-lane divider. A finished result waits in the output register
// while the next operation is taken.
module vertex_normal_accumulator #(
    parameter int VERTICES = vna_pkg::VERTICES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [vna_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // normal_x, normal_y, normal_z
    output logic [vna_pkg::M_TDATA_W-1:0]   m_tdata,
    // has_normal
    output logic                            m_tuser
);

    vna_pkg::vna_cmd_t cmd;
    vna_pkg::vna_sts_t sts;

    vna_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vna_dp #(
        .VERTICES (VERTICES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
